/* sv/svc_pkg.sv */
// svc_pkg: types, colour constants and fixed-point helpers for the sky vertex colour unit
// no dependencies; used by svc_glow and sky_vertex_colour_unit
`timescale 1ns / 1ps
`default_nettype none
package svc_pkg;

	localparam int HOR_DEPTH_DEF = 1024;

	// configuration register indexes
	localparam logic [1:0] REG_SUN_EAST  = 2'd0;
	localparam logic [1:0] REG_SUN_NORTH = 2'd1;
	localparam logic [1:0] REG_SUN_UP    = 2'd2;

	typedef struct packed {
		logic signed [15:0] vert_x;
		logic signed [15:0] vert_y;
		logic signed [15:0] vert_z;
	} vert_t;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} colour_t;

	typedef logic [16:0] col3_t [3];

	localparam col3_t ZEN_DAY    = '{17'd13107, 17'd27525, 17'd55706};
	localparam col3_t HOR_DAY    = '{17'd47186, 17'd53740, 17'd60948};
	localparam col3_t ZEN_NIGHT  = '{17'd1311,  17'd1966,  17'd4588};
	localparam col3_t HOR_NIGHT  = '{17'd5243,  17'd5898,  17'd9175};
	localparam col3_t GROUND     = '{17'd19661, 17'd21627, 17'd24904};
	localparam col3_t GROUND_DIM = '{17'd2949,  17'd3244,  17'd3736};
	localparam col3_t GLOW_COL   = '{17'd65536, 17'd55706, 17'd36045};

	localparam logic [16:0] GLOW_K32 = 17'd58982;
	localparam logic [16:0] GLOW_K4  = 17'd9830;
	localparam logic [16:0] GW_MAX   = 17'd68812;

	// (a*1.0 + (b-a)*w + half) >> 16, clamped at zero
	function automatic logic [17:0] blend(input logic [16:0] a, input logic [16:0] b,
			input logic [16:0] w);
		logic signed [39:0] r;
		r = (40'sd1 <<< 16) * $signed({23'd0, a})
			+ ($signed({23'd0, b}) - $signed({23'd0, a})) * $signed({23'd0, w})
			+ 40'sd32768;
		if (r < 0) return 18'd0;
		return r[33:16];
	endfunction

	// rounded Q16 square
	function automatic logic [16:0] sq16(input logic [16:0] p);
		logic [33:0] s;
		s = 34'(p) * 34'(p) + 34'd32768;
		return s[32:16];
	endfunction

endpackage
`default_nettype wire

/* sv/svc_stream_if.sv */
// svc_stream_if: valid/ready channel carrying one word of a chosen payload type
// depends on nothing; the payload types come from svc_pkg
`timescale 1ns / 1ps
`default_nettype none
interface svc_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/sky_vertex_colour_unit.sv */
// sky_vertex_colour_unit: top level of the sky-dome vertex colour pipeline
// depends on svc_pkg, svc_stream_if and svc_glow
`timescale 1ns / 1ps
`default_nettype none
// Colours one sky-dome vertex per clock unless the output stalls. A vertex word (Q1.15
// east/north/up) enters whenever the output register is free or being emptied; its RGB
// word (Q0.16) comes out after the glow power chain (five squarings, then glow and glow
// weight). The user must write the sun direction registers via cfg_we/cfg_idx/cfg_data
// only while no word is in flight; the block itself does not enforce this. The night/day
// colours derived from them are registered in day_q, then zen_q/hor_q/gnd_q. The horizon
// table is a ROM built at elaboration, HORIZON_TABLE_DEPTH entries, read in stage two.
module sky_vertex_colour_unit #(
	parameter int HORIZON_TABLE_DEPTH = svc_pkg::HOR_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [15:0] cfg_data,
	svc_stream_if.sink       vert,
	svc_stream_if.source     colour
);
	import svc_pkg::*;

	localparam int IW    = $clog2(HORIZON_TABLE_DEPTH);
	localparam int HOR_M = HORIZON_TABLE_DEPTH - 1;
	localparam int NST   = 10;

	typedef logic [16:0] hor_tab_t [HORIZON_TABLE_DEPTH];

	// t[i] = floor(i * w / M), w largest with w^5 M^3 <= 2^80 i^3
	function automatic hor_tab_t build_hor_tab();
		hor_tab_t    tab;
		logic [127:0] lhs, rhs, m3;
		logic [17:0] lo, hi, mid;
		m3 = 128'(HOR_M) * 128'(HOR_M) * 128'(HOR_M);
		for (int i = 0; i < HORIZON_TABLE_DEPTH; i++) begin
			rhs = (128'd1 << 80) * 128'(i) * 128'(i) * 128'(i);
			lo  = 18'd0;
			hi  = 18'd65536;
			while (lo < hi) begin
				mid = (lo + hi + 18'd1) >> 1;
				lhs = 128'(mid) * 128'(mid) * 128'(mid) * 128'(mid) * 128'(mid) * m3;
				if (lhs <= rhs) lo = mid;
				else hi = mid - 18'd1;
			end
			tab[i] = 17'((64'(i) * 64'(lo)) / HOR_M);
		end
		return tab;
	endfunction

	localparam hor_tab_t HOR_TAB = build_hor_tab();

	// sun direction registers
	logic signed [15:0] sun_e_q, sun_n_q, sun_u_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sun_e_q <= 16'sd0;
			sun_n_q <= 16'sd0;
			sun_u_q <= 16'sd32767;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SUN_EAST:  sun_e_q <= cfg_data;
				REG_SUN_NORTH: sun_n_q <= cfg_data;
				REG_SUN_UP:    sun_u_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// day factor and the colours that follow only from it
	logic signed [20:0] day_raw;
	logic [16:0]        day_q;
	logic [16:0]        zen_q [3];
	logic [16:0]        hor_q [3];
	logic [16:0]        gnd_q [3];

	assign day_raw = (21'(sun_u_q) + 21'sd3277) <<< 3;

	always_ff @(posedge clk) begin
		if (day_raw < 0) day_q <= 17'd0;
		else if (day_raw > 21'sd65536) day_q <= 17'd65536;
		else day_q <= day_raw[16:0];
		for (int ch = 0; ch < 3; ch++) begin
			zen_q[ch] <= 17'(blend(ZEN_NIGHT[ch], ZEN_DAY[ch], day_q));
			hor_q[ch] <= 17'(blend(HOR_NIGHT[ch], HOR_DAY[ch], day_q));
			gnd_q[ch] <= 17'(blend(GROUND_DIM[ch], GROUND[ch], day_q));
		end
	end

	// one shared advance: every stage moves when the output register can take a word
	logic           en;
	logic [NST:1]   v_q;

	assign en          = !v_q[NST] || colour.ready;
	assign vert.ready  = en;
	assign colour.valid = v_q[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[NST-1:1], vert.valid};
	end

	// stage 1: dot product terms and horizon table index
	logic signed [17:0] u_full;
	logic [16:0]        u;
	logic [IW+17:0]     idx_prod;
	logic [IW+2:0]      idx_raw;
	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic [IW-1:0]      idx_s1;
	logic               below_s1;

	assign u_full   = 18'sd32768 - 18'(vert.data.vert_z);
	assign u        = u_full[16:0];
	assign idx_prod = (IW+18)'(u) * (IW+18)'(HOR_M) + (IW+18)'(16384);
	assign idx_raw  = idx_prod[IW+17:15];

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1    <= vert.data.vert_x * sun_e_q;
			py_s1    <= vert.data.vert_y * sun_n_q;
			pz_s1    <= vert.data.vert_z * sun_u_q;
			idx_s1   <= (idx_raw > (IW+3)'(HOR_M)) ? IW'(HOR_M) : idx_raw[IW-1:0];
			below_s1 <= vert.data.vert_z[15];
		end
	end

	// stage 2: glow base d and table read
	logic signed [33:0] dot;
	logic signed [33:0] d_round;
	logic [16:0]        d_s2;
	logic [16:0]        t_s2;
	logic               below_s2;

	assign dot     = 34'(px_s1) + 34'(py_s1) + 34'(pz_s1);
	assign d_round = (dot + 34'sd8192) >>> 14;

	always_ff @(posedge clk) begin
		if (en) begin
			if (dot <= 0) d_s2 <= 17'd0;
			else if (d_round > 34'sd65536) d_s2 <= 17'd65536;
			else d_s2 <= d_round[16:0];
			t_s2     <= HOR_TAB[idx_s1];
			below_s2 <= below_s1;
		end
	end

	// glow chain, stages 3 to 9
	logic [16:0] gw_s9;

	svc_glow u_glow (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (d_s2),
		.day    (day_q),
		.gw     (gw_s9)
	);

	// stage 3: zenith-horizon sky colour, then delayed to meet the glow weight
	logic [16:0] c_s [3:9][3];
	logic        below_s [3:9];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < 3; ch++) c_s[3][ch] <= 17'(blend(zen_q[ch], hor_q[ch], t_s2));
			below_s[3] <= below_s2;
			for (int k = 4; k <= 9; k++) begin
				c_s[k]     <= c_s[k-1];
				below_s[k] <= below_s[k-1];
			end
		end
	end

	// stage 10: glow mix or ground colour, saturated, into the output register
	logic [17:0] mix [3];
	logic [15:0] col_s10 [3];

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			mix[ch] = below_s[9] ? 18'(gnd_q[ch]) : blend(c_s[9][ch], GLOW_COL[ch], gw_s9);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < 3; ch++)
				col_s10[ch] <= (mix[ch] > 18'd65535) ? 16'hFFFF : mix[ch][15:0];
		end
	end

	assign colour.data.red   = col_s10[0];
	assign colour.data.green = col_s10[1];
	assign colour.data.blue  = col_s10[2];

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		vert.valid && vert.ready |=> v_q[1]) else $error("accepted word not in stage one");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_q)) else $error("pipeline moved while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NST] && !colour.ready |-> !vert.ready) else $error("input taken while output blocked");
	a_day: assert property (@(posedge clk) disable iff (!arst_n)
		day_q <= 17'd65536) else $error("day factor above one");
endmodule
`default_nettype wire

/* sv/svc_glow.sv */
// svc_glow: sun glow power chain d -> d^4, d^32 -> glow -> glow weight
// depends on svc_pkg; seven register stages, advanced by the shared enable
`timescale 1ns / 1ps
`default_nettype none
module svc_glow (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic [16:0] d,
	input  wire logic [16:0] day,
	output logic      [16:0] gw
);
	import svc_pkg::*;

	logic [16:0] p2_s3, p4_s4, p8_s5, p16_s6, p32_s7;
	logic [16:0] p4_s5, p4_s6, p4_s7;
	logic [16:0] glow_s8, gw_s9;
	logic [34:0] glow_sum;
	logic [33:0] gw_prod;

	assign glow_sum = 35'(GLOW_K32) * 35'(p32_s7) + 35'(GLOW_K4) * 35'(p4_s7) + 35'd32768;
	assign gw_prod  = 34'(glow_s8) * 34'(day) + 34'd32768;

	always_ff @(posedge clk) begin
		if (en) begin
			p2_s3   <= sq16(d);
			p4_s4   <= sq16(p2_s3);
			p8_s5   <= sq16(p4_s4);
			p4_s5   <= p4_s4;
			p16_s6  <= sq16(p8_s5);
			p4_s6   <= p4_s5;
			p32_s7  <= sq16(p16_s6);
			p4_s7   <= p4_s6;
			glow_s8 <= glow_sum[32:16];
			gw_s9   <= gw_prod[32:16];
		end
	end

	assign gw = gw_s9;

	// stages hold no reset, so the checks wait until the chain carries known data
	a_glow_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(glow_s8) |-> glow_s8 <= GW_MAX) else $error("glow above its bound");
	a_p4_order: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({p32_s7, p4_s7}) |-> p32_s7 <= p4_s7 || p4_s7 == 17'd0)
		else $error("d^32 exceeds d^4");
	a_gw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(gw_s9) |-> gw_s9 <= GW_MAX) else $error("glow weight above its bound");
endmodule
`default_nettype wire
